>>> hw/rtl/dbd_pkg.sv
// Package for the detection box decoder: sizes, register indexes and the
// structs that pass between the front, the queue and the back.
// No dependencies.
package dbd_pkg;

  // Proposal limit and the width of the per-frame record counter
  localparam int PROPOSAL_LIMIT = 256;
  localparam int CNT_W          = $clog2(PROPOSAL_LIMIT + 1);

  // Field widths
  localparam int CLASS_W     = 8;
  localparam int SCORE_W     = 16;
  localparam int COORD_W     = 16;
  localparam int PIX_W       = 16;
  localparam int DIM_W       = 12;
  localparam int PROP_W      = 9;
  localparam int MASK_W      = 64;
  localparam int NUM_CLASSES = 64;
  localparam int NUM_EDGES   = 4;

  // Fixed-point positions: edges come in Q2.14, pixels leave in Q12.4
  localparam int COORD_FRAC = 14;
  localparam int PIX_FRAC   = 4;
  localparam int FRAC_SHIFT = COORD_FRAC - PIX_FRAC;

  // Quotient bits retired per divider cycle and the resulting step count
  localparam int DIV_BITS   = 2;
  localparam int DIV_STEPS  = PIX_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Decoupling queue depth
  localparam int QUEUE_DEPTH = 2;

  // Configuration port
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam int REG_IDX_LSB = 3;

  localparam logic [2:0] REG_INPUT_WIDTH   = 3'd0;
  localparam logic [2:0] REG_INPUT_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_SCALED_WIDTH  = 3'd2;
  localparam logic [2:0] REG_SCALED_HEIGHT = 3'd3;
  localparam logic [2:0] REG_ORIG_WIDTH    = 3'd4;
  localparam logic [2:0] REG_ORIG_HEIGHT   = 3'd5;
  localparam logic [2:0] REG_CLASS_MASK    = 3'd6;
  localparam logic [2:0] REG_MAX_PROPOSALS = 3'd7;

  // Incoming record as the front sees it; box order is left, top, right, bottom
  typedef struct packed {
    logic                              frame_start;
    logic                              end_marker;
    logic [CLASS_W-1:0]                cls;
    logic [SCORE_W-1:0]                score;
    logic [NUM_EDGES-1:0][COORD_W-1:0] box;
  } dbd_record_t;

  // Queue entry: either an end-of-frame word or a kept detection
  typedef struct packed {
    logic                              done;
    logic [CLASS_W-1:0]                cls;
    logic [SCORE_W-1:0]                score;
    logic [NUM_EDGES-1:0][COORD_W-1:0] box;
  } dbd_entry_t;

  // Result word
  typedef struct packed {
    logic                            done;
    logic [CLASS_W-1:0]              cls;
    logic [SCORE_W-1:0]              score;
    logic [NUM_EDGES-1:0][PIX_W-1:0] pix;
  } dbd_result_t;

  // Image geometry used by the back
  typedef struct packed {
    logic [DIM_W-1:0] in_w;
    logic [DIM_W-1:0] in_h;
    logic [DIM_W-1:0] sc_w;
    logic [DIM_W-1:0] sc_h;
    logic [DIM_W-1:0] org_w;
    logic [DIM_W-1:0] org_h;
  } dbd_geom_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } dbd_qstat_t;

endpackage

>>> hw/rtl/dbd_front.sv
// Front of the detection box decoder: frame tracking, proposal limit and
// class filtering. Depends on dbd_pkg.
module dbd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  dbd_pkg::dbd_record_t         rec,
  input  logic [dbd_pkg::MASK_W-1:0]   class_mask,
  input  logic [dbd_pkg::PROP_W-1:0]   max_proposals,
  input  dbd_pkg::dbd_qstat_t          qstat,
  output logic                         q_push,
  output dbd_pkg::dbd_entry_t          q_entry
);
  import dbd_pkg::*;

  logic [CNT_W-1:0] record_count;
  logic             frame_stopped;

  logic             accept;
  logic [CNT_W-1:0] cnt_eff;
  logic             stop_eff;
  logic [CNT_W-1:0] limit;
  logic             ends;
  logic             keep;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !qstat.full;

  // A frame start clears the counters before the record is judged
  assign cnt_eff  = rec.frame_start ? '0 : record_count;
  assign stop_eff = rec.frame_start ? 1'b0 : frame_stopped;
  assign limit    = (int'(max_proposals) >= PROPOSAL_LIMIT) ? CNT_W'(PROPOSAL_LIMIT)
                                                             : CNT_W'(max_proposals);

  assign ends = !stop_eff && (rec.end_marker || (cnt_eff >= limit));
  assign keep = !stop_eff && !ends && (int'(rec.cls) < NUM_CLASSES) &&
                class_mask[rec.cls[$clog2(NUM_CLASSES)-1:0]];

  assign q_push = accept && (ends || keep);

  always_comb begin
    q_entry.done  = ends;
    q_entry.cls   = rec.cls;
    q_entry.score = rec.score;
    q_entry.box   = rec.box;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_count  <= '0;
      frame_stopped <= 1'b0;
    end else if (accept) begin
      frame_stopped <= stop_eff || ends;
      record_count  <= (stop_eff || ends) ? cnt_eff : cnt_eff + CNT_W'(1);
    end
  end

endmodule

>>> hw/rtl/dbd_queue.sv
// Short queue between the front and the back of the detection box decoder.
// Depends on dbd_pkg.
module dbd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  dbd_pkg::dbd_entry_t  push_entry,
  input  logic                 pop,
  output dbd_pkg::dbd_entry_t  head,
  output dbd_pkg::dbd_qstat_t  qstat
);
  import dbd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  dbd_entry_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign qstat.full  = (fill == CNT_QW'(QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_QW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/dbd_back.sv
// Back of the detection box decoder: maps each box edge to original pixels
// through two multiplies and a radix-4 divider per lane. Depends on dbd_pkg.
module dbd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  dbd_pkg::dbd_geom_t    geom,
  input  dbd_pkg::dbd_qstat_t   qstat,
  input  dbd_pkg::dbd_entry_t   q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dbd_pkg::dbd_result_t  out_word
);
  import dbd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_PREP = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  localparam int PROD1_W = COORD_W + DIM_W + 1;
  localparam int DIFF_W  = PROD1_W + 1;
  localparam int PROD2_W = DIFF_W + DIM_W + 1;
  localparam int PADSH_W = DIM_W + 1 + COORD_FRAC;
  localparam int NUM_W   = PROD2_W - 1 - FRAC_SHIFT;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [DIV_CNT_W-1:0] step;
  dbd_entry_t           work;
  logic                 out_load;
  logic [NUM_EDGES-1:0][PIX_W-1:0] pix_res;

  assign q_pop    = (state == ST_IDLE) && !qstat.empty;
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!qstat.empty) begin
          state_next = q_head.done ? ST_OUT : ST_MUL1;
        end
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_PREP;
      ST_PREP: state_next = ST_DIV;
      ST_DIV: begin
        if (step == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_PREP) begin
        step <= '0;
      end else if (state == ST_DIV) begin
        step <= step + DIV_CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work <= q_head;
    end
  end

  // End-of-frame words carry zeros in every other field
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word.done  <= work.done;
      out_word.cls   <= work.done ? '0 : work.cls;
      out_word.score <= work.done ? '0 : work.score;
      out_word.pix   <= work.done ? '0 : pix_res;
    end
  end

  for (genvar k = 0; k < NUM_EDGES; k++) begin : g_lane
    logic [DIM_W-1:0]          in_sz;
    logic [DIM_W-1:0]          sc_sz;
    logic [DIM_W-1:0]          org_sz;
    logic [DIM_W-1:0]          sc_eff;
    logic signed [DIM_W+1:0]   span;
    logic signed [DIM_W:0]     pad;
    logic signed [PADSH_W-1:0] pad_sh;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD1_W-1:0] prod1;
    logic signed [PROD2_W-1:0] prod2;
    logic [NUM_W-1:0]          num;
    logic [PIX_W-1:0]          hi;
    logic [DIM_W-1:0]          rem;
    logic [PIX_W-1:0]          nlow;
    logic [PIX_W-1:0]          quo;
    logic                      zero;
    logic                      ovf;
    logic [DIM_W:0]            t1;
    logic [DIM_W:0]            t2;
    logic [DIM_W:0]            d1;
    logic [DIM_W:0]            d2;
    logic                      ge1;
    logic                      ge2;
    logic [DIM_W-1:0]          r1;
    logic [DIM_W-1:0]          r2;

    // Even lanes are horizontal edges, odd lanes vertical
    assign in_sz  = (k % 2 == 0) ? geom.in_w  : geom.in_h;
    assign sc_sz  = (k % 2 == 0) ? geom.sc_w  : geom.sc_h;
    assign org_sz = (k % 2 == 0) ? geom.org_w : geom.org_h;
    assign sc_eff = (sc_sz == '0) ? DIM_W'(1) : sc_sz;

    // Letterbox pad, floored for odd and negative spans
    assign span   = $signed({2'b00, in_sz}) - $signed({2'b00, sc_eff});
    assign pad    = span[DIM_W+1:1];
    assign pad_sh = {pad, {COORD_FRAC{1'b0}}};
    assign diff   = DIFF_W'(prod1) - DIFF_W'(pad_sh);

    // Dropping the low bits first leaves the floored quotient unchanged
    assign num = prod2[PROD2_W-2:FRAC_SHIFT];
    assign hi  = {org_sz - DIM_W'(1), {PIX_FRAC{1'b0}}};

    // Two restoring steps per cycle
    assign t1  = {rem, nlow[PIX_W-1]};
    assign d1  = t1 - {1'b0, sc_eff};
    assign ge1 = (t1 >= {1'b0, sc_eff});
    assign r1  = ge1 ? d1[DIM_W-1:0] : t1[DIM_W-1:0];
    assign t2  = {r1, nlow[PIX_W-2]};
    assign d2  = t2 - {1'b0, sc_eff};
    assign ge2 = (t2 >= {1'b0, sc_eff});
    assign r2  = ge2 ? d2[DIM_W-1:0] : t2[DIM_W-1:0];

    always_ff @(posedge clk) begin
      unique case (state)
        ST_MUL1: prod1 <= $signed(work.box[k]) * $signed({1'b0, in_sz});
        ST_MUL2: prod2 <= diff * $signed({1'b0, org_sz});
        ST_PREP: begin
          zero <= prod2[PROD2_W-1] || (prod2 == '0);
          ovf  <= (num[NUM_W-1:PIX_W] >= (NUM_W - PIX_W)'(sc_eff));
          rem  <= num[PIX_W+DIM_W-1:PIX_W];
          nlow <= num[PIX_W-1:0];
        end
        ST_DIV: begin
          rem  <= r2;
          nlow <= {nlow[PIX_W-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
          quo  <= {quo[PIX_W-DIV_BITS-1:0], ge1, ge2};
        end
        default: begin
        end
      endcase
    end

    assign pix_res[k] = zero ? '0 : ((ovf || (quo > hi)) ? hi : quo);
  end

endmodule

>>> hw/rtl/detection_box_decode.sv
// Top level of the detection box decoder: configuration registers on an
// APB-style port, front, queue and back. Depends on dbd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one detection record per word:
//   frame_start, end_marker, the class, score and four Q2.14 box edges.
//   Output channel (out_valid / out_stall) carries one result word: either an
//   end-of-frame word (frame_done = 1, all else zero) or a kept detection with
//   class, score and four Q12.4 pixel edges clamped to the original image.
//   A word moves when valid is high and stall is low at a rising edge.
//   Dropped records (masked class, class 64 and up, records after the end of
//   a frame) produce no output word.
// Flow:
//   The front judges a record in its accept cycle and writes a two-entry
//   queue, so in_stall rises only while that queue is full.
//   The back takes a kept detection from queue to output register through
//   two multiply stages, a setup step and the radix-4 divider steps per
//   edge (all edges in parallel lanes); an end-of-frame word skips
//   the arithmetic. The back pops the next word only after loading the last.
// Reset (rst, synchronous) empties the queue and output register, clears the
//   frame counters and loads the register defaults. When the receiver stalls,
//   the output word holds, the back waits, and the queue absorbs two more words
//   before in_stall is raised.
module detection_box_decode (
  input  logic                           clk,
  input  logic                           rst,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dbd_pkg::ADDR_W-1:0]     paddr,
  input  logic [dbd_pkg::DATA_W-1:0]     pwdata,
  output logic [dbd_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           frame_start,
  input  logic                           end_marker,
  input  logic [dbd_pkg::CLASS_W-1:0]    det_class,
  input  logic [dbd_pkg::SCORE_W-1:0]    score,
  input  logic signed [dbd_pkg::COORD_W-1:0] box_left,
  input  logic signed [dbd_pkg::COORD_W-1:0] box_top,
  input  logic signed [dbd_pkg::COORD_W-1:0] box_right,
  input  logic signed [dbd_pkg::COORD_W-1:0] box_bottom,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           frame_done,
  output logic [dbd_pkg::CLASS_W-1:0]    out_class,
  output logic [dbd_pkg::SCORE_W-1:0]    out_score,
  output logic [dbd_pkg::PIX_W-1:0]      pix_left,
  output logic [dbd_pkg::PIX_W-1:0]      pix_top,
  output logic [dbd_pkg::PIX_W-1:0]      pix_right,
  output logic [dbd_pkg::PIX_W-1:0]      pix_bottom
);
  import dbd_pkg::*;

  localparam logic [DIM_W-1:0] DIM_RESET  = DIM_W'(300);
  localparam logic [PROP_W-1:0] PROP_RESET = PROP_W'(200);

  // Configuration registers
  dbd_geom_t         geom;
  logic [MASK_W-1:0] class_mask;
  logic [PROP_W-1:0] max_proposals;

  logic              cfg_write;
  logic [2:0]        reg_idx;

  dbd_record_t       rec;
  dbd_qstat_t        qstat;
  logic              q_push;
  logic              q_pop;
  dbd_entry_t        q_entry;
  dbd_entry_t        q_head;
  dbd_result_t       out_word;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[REG_IDX_LSB+2:REG_IDX_LSB];

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.in_w     <= DIM_RESET;
      geom.in_h     <= DIM_RESET;
      geom.sc_w     <= DIM_RESET;
      geom.sc_h     <= DIM_RESET;
      geom.org_w    <= DIM_RESET;
      geom.org_h    <= DIM_RESET;
      class_mask    <= '0;
      max_proposals <= PROP_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_INPUT_WIDTH:   geom.in_w     <= pwdata[DIM_W-1:0];
        REG_INPUT_HEIGHT:  geom.in_h     <= pwdata[DIM_W-1:0];
        REG_SCALED_WIDTH:  geom.sc_w     <= pwdata[DIM_W-1:0];
        REG_SCALED_HEIGHT: geom.sc_h     <= pwdata[DIM_W-1:0];
        REG_ORIG_WIDTH:    geom.org_w    <= pwdata[DIM_W-1:0];
        REG_ORIG_HEIGHT:   geom.org_h    <= pwdata[DIM_W-1:0];
        REG_CLASS_MASK:    class_mask    <= pwdata[MASK_W-1:0];
        REG_MAX_PROPOSALS: max_proposals <= pwdata[PROP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back: zero-extend each register to the data width
  always_comb begin
    unique case (reg_idx)
      REG_INPUT_WIDTH:   prdata = DATA_W'(geom.in_w);
      REG_INPUT_HEIGHT:  prdata = DATA_W'(geom.in_h);
      REG_SCALED_WIDTH:  prdata = DATA_W'(geom.sc_w);
      REG_SCALED_HEIGHT: prdata = DATA_W'(geom.sc_h);
      REG_ORIG_WIDTH:    prdata = DATA_W'(geom.org_w);
      REG_ORIG_HEIGHT:   prdata = DATA_W'(geom.org_h);
      REG_CLASS_MASK:    prdata = DATA_W'(class_mask);
      REG_MAX_PROPOSALS: prdata = DATA_W'(max_proposals);
      default:           prdata = '0;
    endcase
  end

  // Gather the input word; box lanes run left, top, right, bottom
  always_comb begin
    rec.frame_start = frame_start;
    rec.end_marker  = end_marker;
    rec.cls         = det_class;
    rec.score       = score;
    rec.box[0]      = box_left;
    rec.box[1]      = box_top;
    rec.box[2]      = box_right;
    rec.box[3]      = box_bottom;
  end

  dbd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rec           (rec),
    .class_mask    (class_mask),
    .max_proposals (max_proposals),
    .qstat         (qstat),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  dbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .qstat      (qstat)
  );

  dbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .qstat     (qstat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Spread the output word onto the ports
  assign frame_done = out_word.done;
  assign out_class  = out_word.cls;
  assign out_score  = out_word.score;
  assign pix_left   = out_word.pix[0];
  assign pix_top    = out_word.pix[1];
  assign pix_right  = out_word.pix[2];
  assign pix_bottom = out_word.pix[3];

endmodule

>>> hw/rtl/dbd_checker.sv
// Port-level checks for the detection box decoder, bound to the top level.
// Depends on dbd_pkg and detection_box_decode.
module dbd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        frame_done,
  input logic [dbd_pkg::CLASS_W-1:0] out_class,
  input logic [dbd_pkg::SCORE_W-1:0] out_score,
  input logic [dbd_pkg::PIX_W-1:0]   pix_left,
  input logic [dbd_pkg::PIX_W-1:0]   pix_top,
  input logic [dbd_pkg::PIX_W-1:0]   pix_right,
  input logic [dbd_pkg::PIX_W-1:0]   pix_bottom
);
  import dbd_pkg::*;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // End-of-frame words carry nothing else
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |->
      (out_class == '0) && (out_score == '0) && (pix_left == '0) &&
      (pix_top == '0) && (pix_right == '0) && (pix_bottom == '0))
    else $error("end-of-frame word with nonzero fields");

  // Only classes below the mask width can be kept
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_done) |-> (int'(out_class) < NUM_CLASSES))
    else $error("kept detection with out-of-range class");

  // A stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      out_valid && $stable(frame_done) && $stable(out_class) && $stable(out_score) &&
      $stable(pix_left) && $stable(pix_top) && $stable(pix_right) && $stable(pix_bottom))
    else $error("stalled output word changed");

endmodule

bind detection_box_decode dbd_checker u_dbd_checker (.*);
